FILE: hw/rtl/rsp_pkg.sv
// Shared widths, stage word types and cell control for the steering pipeline.
// Used by every module of rrt_steer_point; depends on nothing else.
package rsp_pkg;

	localparam int COORD_BITS  = 32;
	localparam int FRAC_BITS   = 16;
	localparam int RADIUS_BITS = 31;

	localparam int DIFF_W     = COORD_BITS + 1;
	localparam int SQ_W       = 2 * DIFF_W;
	localparam int ROOT_W     = DIFF_W;
	localparam int REM_W      = ROOT_W + 1;
	localparam int SQRT_CELLS = DIFF_W;
	localparam int RR_W       = 2 * RADIUS_BITS;
	localparam int PROD_W     = RADIUS_BITS + DIFF_W;
	localparam int NUM_W      = PROD_W + 1;
	localparam int DEN_W      = ROOT_W + 1;
	localparam int Q_W        = RADIUS_BITS;
	localparam int DIV_CELLS  = Q_W;
	localparam int SUM_W      = COORD_BITS + 2;

	localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = RADIUS_BITS'(1) << FRAC_BITS;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] sx;
		logic signed [COORD_BITS-1:0] sy;
		logic signed [COORD_BITS-1:0] tx;
		logic signed [COORD_BITS-1:0] ty;
		logic                         neg_x;
		logic                         neg_y;
		logic                         near;
		logic                         keep_start;
		logic [PROD_W-1:0]            prod_x;
		logic [PROD_W-1:0]            prod_y;
	} side_t;

	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
		logic [SQ_W-1:0]   rest;
	} sq_t;

	typedef struct packed {
		logic [DEN_W-1:0] rem_x;
		logic [DEN_W-1:0] rem_y;
		logic [Q_W-1:0]   q_x;
		logic [Q_W-1:0]   q_y;
		logic [Q_W-1:0]   rest_x;
		logic [Q_W-1:0]   rest_y;
		logic [DEN_W-1:0] den;
	} dv_t;

	typedef struct packed {
		logic en;
		logic vld;
	} pipe_ctl_t;

endpackage

FILE: hw/rtl/rsp_sqrt_cell.sv
// One digit cell of the integer square root chain: retires one root bit.
// Depends on rsp_pkg for the stage word and sideband types.
module rsp_sqrt_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  rsp_pkg::pipe_ctl_t ctl,
	input  rsp_pkg::sq_t       sq_in,
	input  rsp_pkg::side_t     side_in,
	output logic               vld_q,
	output rsp_pkg::sq_t       sq_q,
	output rsp_pkg::side_t     side_q
);
	import rsp_pkg::*;

	logic [REM_W+1:0] shifted;
	logic [REM_W+1:0] trial;
	logic [REM_W+1:0] diff;
	sq_t              nxt;

	always_comb begin
		shifted  = {sq_in.rem, sq_in.rest[SQ_W-1 -: 2]};
		trial    = {1'b0, sq_in.root, 2'b01};
		diff     = shifted - trial;
		nxt.rest = sq_in.rest << 2;
		if (shifted >= trial) begin
			nxt.rem  = diff[REM_W-1:0];
			nxt.root = {sq_in.root[ROOT_W-2:0], 1'b1};
		end else begin
			nxt.rem  = shifted[REM_W-1:0];
			nxt.root = {sq_in.root[ROOT_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctl.en) begin
			vld_q <= ctl.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			sq_q   <= nxt;
			side_q <= side_in;
		end
	end

endmodule

FILE: hw/rtl/rsp_div_cell.sv
// One cell of the restoring divider chain: one quotient bit for each axis.
// Depends on rsp_pkg for the stage word and sideband types.
module rsp_div_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  rsp_pkg::pipe_ctl_t ctl,
	input  rsp_pkg::dv_t       dv_in,
	input  rsp_pkg::side_t     side_in,
	output logic               vld_q,
	output rsp_pkg::dv_t       dv_q,
	output rsp_pkg::side_t     side_q
);
	import rsp_pkg::*;

	logic [DEN_W:0] sh_x;
	logic [DEN_W:0] sh_y;
	logic [DEN_W:0] df_x;
	logic [DEN_W:0] df_y;
	logic           ge_x;
	logic           ge_y;
	dv_t            nxt;

	always_comb begin
		sh_x = {dv_in.rem_x, dv_in.rest_x[Q_W-1]};
		sh_y = {dv_in.rem_y, dv_in.rest_y[Q_W-1]};
		df_x = sh_x - {1'b0, dv_in.den};
		df_y = sh_y - {1'b0, dv_in.den};
		ge_x = sh_x >= {1'b0, dv_in.den};
		ge_y = sh_y >= {1'b0, dv_in.den};
		nxt.rem_x  = ge_x ? df_x[DEN_W-1:0] : sh_x[DEN_W-1:0];
		nxt.rem_y  = ge_y ? df_y[DEN_W-1:0] : sh_y[DEN_W-1:0];
		nxt.q_x    = {dv_in.q_x[Q_W-2:0], ge_x};
		nxt.q_y    = {dv_in.q_y[Q_W-2:0], ge_y};
		nxt.rest_x = dv_in.rest_x << 1;
		nxt.rest_y = dv_in.rest_y << 1;
		nxt.den    = dv_in.den;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctl.en) begin
			vld_q <= ctl.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			dv_q   <= nxt;
			side_q <= side_in;
		end
	end

endmodule

FILE: hw/rtl/rrt_steer_point.sv
// Top level of the steering block: front stages, root and divider cell chains, output.
// Depends on rsp_pkg, rsp_sqrt_cell and rsp_div_cell.
//
// The block takes one word of a start and a target point in signed Q16.16 on
// the input channel (in_valid, in_ready) and returns one word on the output
// channel (out_valid, out_ready): the target if it lies closer than the step
// radius, else the point one radius from start toward target, with was_clipped
// and overflowed flags.
// step_radius is loaded when step_radius_we is high; change it only while idle.
// From acceptance to out_valid a word passes three front stages, a
// chain of 33 root cells, one setup stage, a chain of 31 divider cells and
// the output register. Each cell retires one bit of the root or of the two
// quotients, so a new word is taken in every cycle unless the output stalls.
// The whole pipeline advances together; when out_valid is high and out_ready
// low, every stage holds and in_ready drops in the same cycle.
// Reset clears every stage valid bit and loads step_radius with 1.0.
module rrt_steer_point (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  step_radius_we,
	input  logic [rsp_pkg::RADIUS_BITS-1:0]       step_radius,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [rsp_pkg::COORD_BITS-1:0] start_x,
	input  logic signed [rsp_pkg::COORD_BITS-1:0] start_y,
	input  logic signed [rsp_pkg::COORD_BITS-1:0] target_x,
	input  logic signed [rsp_pkg::COORD_BITS-1:0] target_y,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [rsp_pkg::COORD_BITS-1:0] new_x,
	output logic signed [rsp_pkg::COORD_BITS-1:0] new_y,
	output logic                                  was_clipped,
	output logic                                  overflowed
);
	import rsp_pkg::*;

	localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
	localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_MAX - SUM_W'(1);
	localparam logic signed [COORD_BITS-1:0] C_MAX = SUM_MAX[COORD_BITS-1:0];
	localparam logic signed [COORD_BITS-1:0] C_MIN = SUM_MIN[COORD_BITS-1:0];

	logic [RADIUS_BITS-1:0] radius_q;
	logic                   en;

	logic                   v_s1, v_s2, v_s3, v_s4;
	side_t                  side_s1, side_s2, side_s3, side_s4;
	logic [DIFF_W-1:0]      ax_s1, ay_s1;
	logic [RADIUS_BITS-1:0] r_s1;
	logic [SQ_W-1:0]        sqx_s2, sqy_s2;
	logic [RR_W-1:0]        rr_s2;
	logic [SQ_W-1:0]        s_s3;
	dv_t                    dv_s4;

	logic signed [DIFF_W-1:0] dx, dy;
	logic [SQ_W-1:0]          s_sum;
	side_t                    side_n1, side_n2, side_n3;

	logic  sq_vld  [SQRT_CELLS+1];
	sq_t   sq_arr  [SQRT_CELLS+1];
	side_t sq_side [SQRT_CELLS+1];
	logic  dv_vld  [DIV_CELLS+1];
	dv_t   dv_arr  [DIV_CELLS+1];
	side_t dv_side [DIV_CELLS+1];

	logic [ROOT_W-1:0]       root_n;
	logic [NUM_W-1:0]        num_x, num_y;
	dv_t                     dv_n;
	side_t                   side_n4;

	side_t                   side_f;
	dv_t                     dv_f;
	logic signed [SUM_W-1:0] sum_x, sum_y;
	logic signed [SUM_W-1:0] q_xe, q_ye;
	logic signed [COORD_BITS-1:0] res_x, res_y;
	logic                    res_clip, res_ovf;

	logic                         out_vld_q;
	logic signed [COORD_BITS-1:0] new_x_q, new_y_q;
	logic                         clip_q, ovf_q;

	assign en       = !out_vld_q || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
		end else if (step_radius_we) begin
			radius_q <= step_radius;
		end
	end

	always_comb begin
		dx = {target_x[COORD_BITS-1], target_x} - {start_x[COORD_BITS-1], start_x};
		dy = {target_y[COORD_BITS-1], target_y} - {start_y[COORD_BITS-1], start_y};
	end

	always_comb begin
		side_n1            = '0;
		side_n1.sx         = start_x;
		side_n1.sy         = start_y;
		side_n1.tx         = target_x;
		side_n1.ty         = target_y;
		side_n1.neg_x      = dx[DIFF_W-1];
		side_n1.neg_y      = dy[DIFF_W-1];
		side_n2            = side_s1;
		side_n2.keep_start = (r_s1 == '0);
		side_n2.prod_x     = PROD_W'(r_s1 * ax_s1);
		side_n2.prod_y     = PROD_W'(r_s1 * ay_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= sq_vld[SQRT_CELLS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1            <= side_n1;
			ax_s1              <= dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
			ay_s1              <= dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
			r_s1               <= radius_q;

			side_s2            <= side_n2;
			sqx_s2             <= SQ_W'(ax_s1 * ax_s1);
			sqy_s2             <= SQ_W'(ay_s1 * ay_s1);
			rr_s2              <= RR_W'(r_s1 * r_s1);

			side_s3            <= side_n3;
			s_s3               <= s_sum;

			side_s4            <= side_n4;
			dv_s4              <= dv_n;
		end
	end

	always_comb begin
		s_sum        = sqx_s2 + sqy_s2;
		side_n3      = side_s2;
		side_n3.near = s_sum < SQ_W'(rr_s2);
	end

	assign sq_vld[0]  = v_s3;
	assign sq_arr[0]  = '{rem: '0, root: '0, rest: s_s3};
	assign sq_side[0] = side_s3;

	for (genvar i = 0; i < SQRT_CELLS; i++) begin : g_sqrt
		rsp_sqrt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     ('{en: en, vld: sq_vld[i]}),
			.sq_in   (sq_arr[i]),
			.side_in (sq_side[i]),
			.vld_q   (sq_vld[i+1]),
			.sq_q    (sq_arr[i+1]),
			.side_q  (sq_side[i+1])
		);
	end

	always_comb begin
		root_n     = sq_arr[SQRT_CELLS].root;
		num_x      = {sq_side[SQRT_CELLS].prod_x, 1'b0} + NUM_W'(root_n);
		num_y      = {sq_side[SQRT_CELLS].prod_y, 1'b0} + NUM_W'(root_n);
		dv_n.rem_x  = num_x[NUM_W-1:Q_W];
		dv_n.rem_y  = num_y[NUM_W-1:Q_W];
		dv_n.rest_x = num_x[Q_W-1:0];
		dv_n.rest_y = num_y[Q_W-1:0];
		dv_n.q_x    = '0;
		dv_n.q_y    = '0;
		dv_n.den    = {root_n, 1'b0};
		side_n4            = sq_side[SQRT_CELLS];
		side_n4.keep_start = sq_side[SQRT_CELLS].keep_start || (root_n == '0);
	end

	assign dv_vld[0]  = v_s4;
	assign dv_arr[0]  = dv_s4;
	assign dv_side[0] = side_s4;

	for (genvar j = 0; j < DIV_CELLS; j++) begin : g_div
		rsp_div_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     ('{en: en, vld: dv_vld[j]}),
			.dv_in   (dv_arr[j]),
			.side_in (dv_side[j]),
			.vld_q   (dv_vld[j+1]),
			.dv_q    (dv_arr[j+1]),
			.side_q  (dv_side[j+1])
		);
	end

	always_comb begin
		side_f = dv_side[DIV_CELLS];
		dv_f   = dv_arr[DIV_CELLS];
		q_xe   = SUM_W'(dv_f.q_x);
		q_ye   = SUM_W'(dv_f.q_y);
		sum_x  = side_f.neg_x ? SUM_W'(side_f.sx) - q_xe : SUM_W'(side_f.sx) + q_xe;
		sum_y  = side_f.neg_y ? SUM_W'(side_f.sy) - q_ye : SUM_W'(side_f.sy) + q_ye;
		res_ovf  = 1'b0;
		res_clip = 1'b1;
		if (side_f.near) begin
			res_x    = side_f.tx;
			res_y    = side_f.ty;
			res_clip = 1'b0;
		end else if (side_f.keep_start) begin
			res_x = side_f.sx;
			res_y = side_f.sy;
		end else begin
			if (sum_x > SUM_MAX) begin
				res_x   = C_MAX;
				res_ovf = 1'b1;
			end else if (sum_x < SUM_MIN) begin
				res_x   = C_MIN;
				res_ovf = 1'b1;
			end else begin
				res_x = sum_x[COORD_BITS-1:0];
			end
			if (sum_y > SUM_MAX) begin
				res_y   = C_MAX;
				res_ovf = 1'b1;
			end else if (sum_y < SUM_MIN) begin
				res_y   = C_MIN;
				res_ovf = 1'b1;
			end else begin
				res_y = sum_y[COORD_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= dv_vld[DIV_CELLS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			new_x_q <= res_x;
			new_y_q <= res_y;
			clip_q  <= res_clip;
			ovf_q   <= res_ovf;
		end
	end

	assign out_valid   = out_vld_q;
	assign new_x       = new_x_q;
	assign new_y       = new_y_q;
	assign was_clipped = clip_q;
	assign overflowed  = ovf_q;

`ifndef SYNTHESIS
	a_ready_follows_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("in_ready does not follow the output stall");

	a_ovf_only_clipped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflowed |-> was_clipped)
		else $error("overflow reported for a returned target");

	a_ovf_at_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflowed |-> (new_x == C_MAX || new_x == C_MIN ||
		                             new_y == C_MAX || new_y == C_MIN))
		else $error("overflow reported without a saturated coordinate");
`endif

endmodule

FILE: tb/tb_rrt_steer_point.sv
// Self-checking regression for rrt_steer_point: random and corner-case points
// are streamed through both handshakes and checked against an exact predictor.
// Depends on rsp_pkg and the rrt_steer_point RTL.
`timescale 1ns / 1ps

class steer_scoreboard;
	typedef struct {
		logic signed [rsp_pkg::COORD_BITS-1:0] x;
		logic signed [rsp_pkg::COORD_BITS-1:0] y;
		logic                                  clipped;
		logic                                  ovf;
	} step_t;

	step_t                          pending[$];
	logic [rsp_pkg::RADIUS_BITS-1:0] radius;
	int                             mismatches;

	function new();
		radius = rsp_pkg::RADIUS_RESET;
		mismatches = 0;
	endfunction

	function logic signed [63:0] scaled_offset(logic signed [63:0] d, logic [127:0] root);
		logic [127:0] mag;
		logic [127:0] q;
		mag = (d < 0) ? 128'(-d) : 128'(d);
		q = (2 * 128'(radius) * mag + root) / (2 * root);
		return (d < 0) ? -$signed(64'(q)) : $signed(64'(q));
	endfunction

	function logic signed [63:0] clamp(logic signed [63:0] v, inout logic ovf);
		if (v > 64'sh7FFFFFFF) begin
			ovf = 1'b1;
			return 64'sh7FFFFFFF;
		end
		if (v < -64'sh80000000) begin
			ovf = 1'b1;
			return -64'sh80000000;
		end
		return v;
	endfunction

	function void note_input(logic signed [31:0] sx, logic signed [31:0] sy,
			logic signed [31:0] tx, logic signed [31:0] ty);
		logic signed [63:0] dx, dy, nx, ny;
		logic [127:0] ax, ay, s, root, cand;
		step_t e;
		dx = 64'(tx) - 64'(sx);
		dy = 64'(ty) - 64'(sy);
		ax = (dx < 0) ? 128'(-dx) : 128'(dx);
		ay = (dy < 0) ? 128'(-dy) : 128'(dy);
		s = ax * ax + ay * ay;
		e.ovf = 1'b0;
		if (s < 128'(radius) * 128'(radius)) begin
			nx = tx;
			ny = ty;
			e.clipped = 1'b0;
		end else begin
			e.clipped = 1'b1;
			root = 0;
			for (int b = 40; b >= 0; b--) begin
				cand = root | (128'(1) << b);
				if (cand * cand <= s)
					root = cand;
			end
			if (root == 0 || radius == 0) begin
				nx = sx;
				ny = sy;
			end else begin
				nx = clamp(64'(sx) + scaled_offset(dx, root), e.ovf);
				ny = clamp(64'(sy) + scaled_offset(dy, root), e.ovf);
			end
		end
		e.x = nx[31:0];
		e.y = ny[31:0];
		pending.push_back(e);
	endfunction

	function void check_result(logic signed [31:0] x, logic signed [31:0] y,
			logic clipped, logic ovf);
		step_t e;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected word: x=%h y=%h clip=%b ovf=%b", x, y, clipped, ovf);
			return;
		end
		e = pending.pop_front();
		if (x !== e.x || y !== e.y || clipped !== e.clipped || ovf !== e.ovf) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: exp x=%h y=%h clip=%b ovf=%b, got x=%h y=%h clip=%b ovf=%b",
					e.x, e.y, e.clipped, e.ovf, x, y, clipped, ovf);
		end
	endfunction
endclass

module tb_rrt_steer_point;
	import rsp_pkg::*;

	logic                          clk;
	logic                          arst_n;
	logic                          step_radius_we;
	logic [RADIUS_BITS-1:0]        step_radius;
	logic                          in_valid;
	logic                          in_ready;
	logic signed [COORD_BITS-1:0] start_x, start_y, target_x, target_y;
	logic                          out_valid;
	logic                          out_ready;
	logic signed [COORD_BITS-1:0] new_x, new_y;
	logic                          was_clipped;
	logic                          overflowed;

	steer_scoreboard sb = new();
	int  cycles;
	bit  hold_req;

	localparam int LIMIT = 2000000;

	rrt_steer_point u_top (
		.clk(clk), .arst_n(arst_n),
		.step_radius_we(step_radius_we), .step_radius(step_radius),
		.in_valid(in_valid), .in_ready(in_ready),
		.start_x(start_x), .start_y(start_y), .target_x(target_x), .target_y(target_y),
		.out_valid(out_valid), .out_ready(out_ready),
		.new_x(new_x), .new_y(new_y), .was_clipped(was_clipped), .overflowed(overflowed)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("rrt_steer_point regression: fail");
			$finish;
		end
		if (out_valid && out_ready)
			sb.check_result(new_x, new_y, was_clipped, overflowed);
	end

	initial begin
		int run, gap;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready = 1'b0;
				repeat (300) @(negedge clk);
				hold_req = 1'b0;
			end
			run = $urandom_range(0, 3) == 0 ? 60 : $urandom_range(1, 20);
			gap = $urandom_range(0, 6);
			out_ready = 1'b1;
			repeat (run - 1) @(negedge clk);
			if (gap != 0) begin
				@(negedge clk);
				out_ready = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
	end

	task automatic send_word(logic signed [31:0] sx, logic signed [31:0] sy,
			logic signed [31:0] tx, logic signed [31:0] ty);
		@(negedge clk);
		in_valid = 1'b1;
		start_x = sx;
		start_y = sy;
		target_x = tx;
		target_y = ty;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_input(sx, sy, tx, ty);
	endtask

	task automatic idle_cycles(int n);
		@(negedge clk);
		in_valid = 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task automatic drain();
		idle_cycles(0);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic load_radius(logic [RADIUS_BITS-1:0] r);
		@(negedge clk);
		step_radius_we = 1'b1;
		step_radius = r;
		@(negedge clk);
		step_radius_we = 1'b0;
		sb.radius = r;
	endtask

	task automatic random_word();
		logic signed [31:0] sx, sy, tx, ty;
		int span;
		sx = $urandom;
		sy = $urandom;
		case ($urandom_range(0, 3))
			0: begin
				tx = $urandom;
				ty = $urandom;
			end
			default: begin
				span = $urandom_range(1, 31);
				tx = sx + ($signed($urandom) >>> span);
				ty = sy + ($signed($urandom) >>> span);
			end
		endcase
		send_word(sx, sy, tx, ty);
	endtask

	initial begin
		logic [RADIUS_BITS-1:0] radii[6];
		int burst;
		arst_n = 1'b0;
		step_radius_we = 1'b0;
		step_radius = '0;
		in_valid = 1'b0;
		start_x = '0;
		start_y = '0;
		target_x = '0;
		target_y = '0;
		cycles = 0;
		hold_req = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		radii = '{RADIUS_RESET, '0, {RADIUS_BITS{1'b1}}, 31'h0000_8000,
			RADIUS_BITS'($urandom), RADIUS_BITS'($urandom_range(1, 1 << 20))};
		for (int p = 0; p < 6; p++) begin
			if (p != 0)
				load_radius(radii[p]);
			send_word(32'sh0, 32'sh0, 32'sh0, 32'sh0);
			send_word(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
			send_word(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF);
			send_word(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFE);
			for (int n = 0; n < 320;) begin
				if (p == 2 && n == 0)
					hold_req = 1'b1;
				burst = $urandom_range(1, 40);
				for (int k = 0; k < burst; k++)
					random_word();
				n += burst;
				if ($urandom_range(0, 2) == 0)
					idle_cycles($urandom_range(1, 12));
			end
			drain();
		end

		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("rrt_steer_point regression: pass");
		else
			$display("rrt_steer_point regression: fail");
		$finish;
	end
endmodule

FILE: sim.f
hw/rtl/rsp_pkg.sv
hw/rtl/rsp_sqrt_cell.sv
hw/rtl/rsp_div_cell.sv
hw/rtl/rrt_steer_point.sv
tb/tb_rrt_steer_point.sv
